// ----- hdl/nlsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Natural log series unit package
// Widths and constants shared by the log unit modules.
// ----------------------------------------------------------------------------
package nlsu_pkg;
	localparam int FracBits     = 24;
	localparam int XWidth       = 29;
	localparam int LnWidth      = 30;
	localparam int ThrWidth     = 24;
	localparam int CntWidth     = 10;
	localparam int TermLimitMax = 1023;
	localparam int MagWidth     = FracBits;      // r and its powers stay below one
	localparam int SumWidth     = FracBits + 12; // enough headroom for any term sum
	localparam int DivWidth     = XWidth + 1;    // x + 1 fits here

	localparam logic [ThrWidth-1:0] ThrReset   = ThrWidth'(17);
	localparam logic [CntWidth-1:0] LimitReset = CntWidth'(512);

	localparam logic CfgThreshold = 1'b0;
	localparam logic CfgTermLimit = 1'b1;

	typedef enum logic [1:0] {
		OP_FRAC = 2'd0,   // fractional quotient num/den, FracBits steps
		OP_INT  = 2'd1    // integer quotient num/den, MagWidth steps
	} div_op_t;

	typedef struct packed {
		logic                start;
		div_op_t             op;
		logic [DivWidth-1:0] num;
		logic [DivWidth-1:0] den;
	} div_req_t;
endpackage
`default_nettype wire

// ----- hdl/nlsu_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle, fractional or integer mode.
// ----------------------------------------------------------------------------
module nlsu_divider
	import nlsu_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire div_req_t            req,
	output logic                     done,
	output logic [MagWidth-1:0]      quot
);
	logic [DivWidth:0]   rem_q;
	logic [DivWidth-1:0] den_q;
	logic [MagWidth-1:0] num_q;
	logic [MagWidth-1:0] quot_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                int_q;
	logic [DivWidth:0]   rem_sh;
	logic                ge;

	// In integer mode the dividend bits are shifted in from num_q.
	assign rem_sh = int_q ? {rem_q[DivWidth-1:0], num_q[MagWidth-1]} : {rem_q[DivWidth-1:0], 1'b0};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				int_q  <= (req.op == OP_INT);
				den_q  <= req.den;
				cnt_q  <= 5'(MagWidth - 1);
				quot_q <= '0;
				if (req.op == OP_INT) begin
					rem_q <= '0;
					num_q <= req.num[MagWidth-1:0];
				end else begin
					rem_q <= {1'b0, req.num};
					num_q <= '0;
				end
			end else if (busy_q) begin
				rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quot_q <= {quot_q[MagWidth-2:0], ge};
				num_q  <= {num_q[MagWidth-2:0], 1'b0};
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quot = quot_q;
endmodule
`default_nettype wire

// ----- hdl/natural_log_series_unit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Natural log series unit
// Computes ln(x) by the atanh series with one shared divider and multiplier.
// ----------------------------------------------------------------------------
// Sequence for one term: the divider forms r, S_RDIV takes the quotient, S_SQ
// squares it and S_MUL makes the decision; each further term adds the multiply
// and divider start in S_MUL, the divider steps in S_TDIV and taking the
// quotient. A zero argument gives its result in the cycle after acceptance.
// One item at a time: in_ready is low from acceptance until the result is
// taken. Reset clears the sequencer and loads stop_threshold 17, term_limit 512.
module natural_log_series_unit_top
	import nlsu_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [XWidth-1:0]          x_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [LnWidth-1:0]       ln_value,
	output logic [CntWidth-1:0]             terms_used,
	output logic                            capped,
	output logic                            bad_input,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [ThrWidth-1:0]        cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_RDIV, S_SQ, S_MUL, S_TDIV, S_DONE
	} state_t;

	state_t               state_q;
	logic [ThrWidth-1:0]  thr_q;
	logic [CntWidth-1:0]  limit_q;
	logic [CntWidth-1:0]  lim_eff_q;
	logic [CntWidth-1:0]  count_q;
	logic [MagWidth-1:0]  r2_q;
	logic [MagWidth-1:0]  p_q;
	logic [MagWidth-1:0]  term_q;
	logic [SumWidth-1:0]  sum_q;
	logic                 neg_q;
	div_req_t             dreq;
	logic                 ddone;
	logic [MagWidth-1:0]  dquot;
	logic [MagWidth-1:0]  mul_a;
	logic [MagWidth-1:0]  mul_b;
	logic [2*MagWidth-1:0] prod;
	logic [DivWidth-1:0]  one_w;
	logic [DivWidth-1:0]  x_w;
	logic [CntWidth:0]    odd;
	logic                 more;
	logic [SumWidth:0]    dbl;
	logic [LnWidth-1:0]   ln_sat;

	// This configuration port is always ready; writes must arrive only when idle, which the block does not enforce.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= ThrReset;
			limit_q <= LimitReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgThreshold: thr_q   <= cfg_data;
				CfgTermLimit: limit_q <= cfg_data[CntWidth-1:0];
				default: ;
			endcase
		end
	end

	nlsu_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	// The single shared multiplier: r*r first, then p*r2 once per term.
	assign mul_a = (state_q == S_SQ) ? dquot : p_q;
	assign mul_b = (state_q == S_SQ) ? dquot : r2_q;
	assign prod  = mul_a * mul_b;

	assign one_w = DivWidth'(1) << FracBits;
	assign x_w   = DivWidth'(x_value);
	// Next term's divisor is 2*(count+1)-1 = 2*count+1.
	assign odd   = {count_q, 1'b1};
	// Keep summing while the last term exceeds the threshold and the limit allows.
	assign more  = (term_q > thr_q) && (count_q < lim_eff_q);

	always_comb begin
		dreq = '0;
		if (state_q == S_IDLE && in_valid && x_value != '0) begin
			dreq.start = 1'b1;
			dreq.op    = OP_FRAC;
			dreq.num   = (x_w < one_w) ? one_w - x_w : x_w - one_w;
			dreq.den   = x_w + one_w;
		end else if (state_q == S_MUL) begin
			dreq.start = 1'b1;
			dreq.op    = OP_INT;
			dreq.num   = DivWidth'(prod[2*MagWidth-1:FracBits]);
			dreq.den   = DivWidth'(odd);
		end
	end

	// Doubled sum with saturation to the signed result range.
	always_comb begin
		dbl = {sum_q, 1'b0};
		if (neg_q) begin
			ln_sat = (dbl > (SumWidth+1)'(1) << (LnWidth-1))
				? LnWidth'(1) << (LnWidth-1) : LnWidth'(-dbl);
		end else begin
			ln_sat = (dbl > ((SumWidth+1)'(1) << (LnWidth-1)) - (SumWidth+1)'(1))
				? {1'b0, {(LnWidth-1){1'b1}}} : dbl[LnWidth-1:0];
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						neg_q     <= x_value < XWidth'(one_w);
						lim_eff_q <= (limit_q == '0) ? CntWidth'(1) : limit_q;
						if (x_value == '0) begin
							ln_value   <= '0;
							terms_used <= '0;
							capped     <= 1'b0;
							bad_input  <= 1'b1;
							out_valid  <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_RDIV;
						end
					end
				end
				S_RDIV: if (ddone) begin
					p_q     <= dquot;
					term_q  <= dquot;
					sum_q   <= SumWidth'(dquot);
					count_q <= CntWidth'(1);
					state_q <= S_SQ;
				end
				S_SQ: begin
					r2_q    <= prod[2*MagWidth-1:FracBits];
					state_q <= S_MUL;
				end
				S_MUL: begin
					// Decide on the term finished before; the divider starts either way, the next term only if needed.
					if (more) begin
						p_q     <= prod[2*MagWidth-1:FracBits];
						count_q <= count_q + CntWidth'(1);
						state_q <= S_TDIV;
					end else begin
						ln_value   <= ln_sat;
						terms_used <= count_q;
						capped     <= term_q > thr_q;
						bad_input  <= 1'b0;
						out_valid  <= 1'b1;
						state_q    <= S_DONE;
					end
				end
				S_TDIV: if (ddone) begin
					term_q  <= dquot;
					sum_q   <= sum_q + SumWidth'(dquot);
					state_q <= S_MUL;
				end
				S_DONE: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is held only in the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_DONE) else $error("result outside done state");
	// The count never passes the effective limit while working.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TDIV) |-> count_q <= lim_eff_q) else $error("term count overrun");
	// An accepted zero argument yields a flagged result next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && x_value == '0) |=> out_valid && bad_input)
		else $error("zero argument not flagged");
endmodule
`default_nettype wire

// ----- tb/natural_log_series_unit_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Natural log series unit testbench
// Sends arguments through the valid/ready input, predicts ln(x), the term
// count and the flags with a bit-exact series model, and checks every result.
// ----------------------------------------------------------------------------
module natural_log_series_unit_top_tb;
	import nlsu_pkg::*;

	// One predicted or observed result.
	typedef struct {
		logic signed [LnWidth-1:0] ln;
		logic [CntWidth-1:0]       terms;
		logic                      capped;
		logic                      bad;
	} ln_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [XWidth-1:0]         x_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [LnWidth-1:0] ln_value;
	logic [CntWidth-1:0]       terms_used;
	logic                      capped;
	logic                      bad_input;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = CfgThreshold;
	logic [ThrWidth-1:0]       cfg_data = '0;

	// Our own copy of the two configuration registers.
	logic [ThrWidth-1:0] eps_reg = ThrReset;
	logic [CntWidth-1:0] limit_reg = LimitReset;

	// Predicted results, oldest first.
	ln_result_t pending_logs[$];

	int  error_count = 0;
	bit  idling_on = 1'b1;   // random gaps on both sides when set
	int  hold_cycles = 0;    // a long receiver hold-off, counted down per cycle

	localparam logic [XWidth-1:0] XOne = XWidth'(1) << FracBits;
	localparam logic [XWidth-1:0] XMax = '1;

	natural_log_series_unit_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_value    (x_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ln_value   (ln_value),
		.terms_used (terms_used),
		.capped     (capped),
		.bad_input  (bad_input),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Series model of ln(x). All magnitudes carry FracBits fraction bits and
	// every step truncates, as the hardware does. r and its powers stay below
	// one, so 64-bit products are wide enough.
	function automatic ln_result_t compute_ln(input logic [XWidth-1:0] x);
		ln_result_t res;
		logic [63:0] one_fx, mag, den, rem, r, r2, pw, term, sum, count, dbl, lim;
		bit neg;
		one_fx = 64'd1 << FracBits;
		res.ln = '0;
		res.terms = '0;
		res.capped = 1'b0;
		res.bad = 1'b0;
		// A zero argument has no logarithm; the block flags it and returns zero.
		if (x == '0) begin
			res.bad = 1'b1;
			return res;
		end
		// The limit register is clamped into 1..TermLimitMax.
		lim = 64'(limit_reg);
		if (lim < 1) lim = 1;
		if (lim > TermLimitMax) lim = TermLimitMax;
		neg = (64'(x) < one_fx);
		mag = neg ? one_fx - 64'(x) : 64'(x) - one_fx;
		den = 64'(x) + one_fx;
		// Restoring division for r = |x-1| / (x+1).
		rem = mag;
		r = 0;
		for (int i = 0; i < FracBits; i++) begin
			rem = rem << 1;
			r = r << 1;
			if (rem >= den) begin
				rem = rem - den;
				r = r | 64'd1;
			end
		end
		r2 = (r * r) >> FracBits;
		pw = r;
		term = pw;
		sum = term;
		count = 1;
		while (term > 64'(eps_reg) && count < lim) begin
			pw = (pw * r2) >> FracBits;
			count++;
			term = pw / (2 * count - 1);
			sum += term;
		end
		// Double the sum and saturate into the signed output range.
		dbl = sum << 1;
		if (neg) begin
			if (dbl > (64'd1 << (LnWidth - 1))) dbl = 64'd1 << (LnWidth - 1);
			res.ln = LnWidth'(64'd0 - dbl);
		end else begin
			if (dbl > ((64'd1 << (LnWidth - 1)) - 1)) dbl = (64'd1 << (LnWidth - 1)) - 1;
			res.ln = LnWidth'(dbl);
		end
		res.terms = CntWidth'(count);
		res.capped = (term > 64'(eps_reg));
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Result checker and receiver pacing. The transfer is judged on the values
	// present at the edge, then out_ready for the next edge is chosen once.
	always @(posedge clk) begin
		ln_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_logs.size() == 0) begin
				report_mismatch("unexpected result, ln_value", ln_value, 0);
			end else begin
				want = pending_logs.pop_front();
				if (ln_value !== want.ln) report_mismatch("ln_value", ln_value, want.ln);
				if (terms_used !== want.terms)
					report_mismatch("terms_used", terms_used, want.terms);
				if (capped !== want.capped) report_mismatch("capped", capped, want.capped);
				if (bad_input !== want.bad) report_mismatch("bad_input", bad_input, want.bad);
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (idling_on) begin
			out_ready <= ($urandom_range(0, 99) >= 33);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offers one argument and keeps it steady until the transfer happens. The
	// prediction is made at the accepting edge, under the current registers.
	task automatic send_x(input logic [XWidth-1:0] x);
		if (idling_on && $urandom_range(0, 99) < 33)
			repeat ($urandom_range(1, 6)) @(posedge clk);
		@(posedge clk);
		in_valid <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (!in_ready);
		pending_logs.push_back(compute_ln(x));
		in_valid <= 1'b0;
		x_value <= XWidth'($urandom);
	endtask

	// Waits until every predicted result has arrived, plus a short settle.
	task automatic wait_drained();
		while (pending_logs.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Writes one register; only called while the block is idle.
	task automatic write_reg(input logic idx, input logic [ThrWidth-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CfgThreshold) eps_reg = data;
		else limit_reg = data[CntWidth-1:0];
		cfg_valid <= 1'b0;
	endtask

	// Argument near one, where the series converges quickly.
	function automatic logic [XWidth-1:0] near_one();
		int span;
		span = 1 << $urandom_range(0, 24);
		return XOne - XWidth'(span / 2) + XWidth'($urandom_range(0, span - 1));
	endfunction

	// Reset registers: zero, one, its neighbors, the extremes and some
	// ordinary values on both sides of one.
	task automatic test_default_registers();
		send_x('0);
		send_x(XOne);
		send_x(XOne + 1);
		send_x(XOne - 1);
		send_x(XOne << 1);
		send_x(XOne >> 1);
		send_x(XOne * 3);
		send_x(XOne / 10);
		send_x(XWidth'(1));
		send_x(XMax);
		wait_drained();
	endtask

	// Register extremes: the largest limit with a zero threshold, a zero limit
	// (clamped up to one), upper data bits that fall outside the limit field,
	// and the largest threshold, then a threshold of 1000 with a limit of 20.
	task automatic test_register_extremes();
		write_reg(CfgThreshold, '0);
		write_reg(CfgTermLimit, ThrWidth'(TermLimitMax));
		send_x(XWidth'(1));
		send_x(XMax);
		send_x(XOne + 12345);
		wait_drained();
		write_reg(CfgTermLimit, '0);
		send_x(XOne * 5);
		send_x(XOne / 7);
		wait_drained();
		write_reg(CfgTermLimit, 24'hFFFC05);
		write_reg(CfgThreshold, '1);
		send_x(XOne * 2);
		send_x('0);
		send_x(XOne);
		wait_drained();
		write_reg(CfgThreshold, ThrWidth'(1000));
		write_reg(CfgTermLimit, ThrWidth'(20));
		send_x(XMax - 1);
		send_x(XOne - 3);
		wait_drained();
	endtask

	// The receiver refuses results for a long stretch while arguments keep
	// coming; the block holds its one result and stops taking input.
	task automatic test_output_stall();
		hold_cycles = 3000;
		repeat (4) send_x(near_one());
		wait_drained();
	endtask

	// Random phases under random settings. Most arguments sit near one; the
	// rest span the whole field and can run into the term limit, which is kept
	// small so the run stays short. One phase runs with no idling at all.
	task automatic test_random_arguments();
		logic [XWidth-1:0] x;
		for (int phase = 0; phase < 6; phase++) begin
			idling_on = (phase != 3);
			case ($urandom_range(0, 2))
				0: write_reg(CfgThreshold, ThrWidth'($urandom_range(0, 64)));
				1: write_reg(CfgThreshold, ThrWidth'($urandom));
				default: write_reg(CfgThreshold, ThrWidth'($urandom_range(0, 4096)));
			endcase
			write_reg(CfgTermLimit, ThrWidth'($urandom_range(1, 48)));
			for (int n = 0; n < 20; n++) begin
				if ($urandom_range(0, 99) < 60) x = near_one();
				else x = XWidth'($urandom);
				send_x(x);
			end
			wait_drained();
		end
		// A last batch under the largest limit, arguments close to one.
		idling_on = 1'b1;
		write_reg(CfgThreshold, ThrWidth'($urandom_range(1, 64)));
		write_reg(CfgTermLimit, ThrWidth'(TermLimitMax));
		repeat (10) send_x(XOne - XWidth'(1 << 20) + XWidth'($urandom_range(0, 1 << 21)));
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_registers();
		test_register_extremes();
		test_output_stall();
		test_random_arguments();
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("natural_log_series_unit_top verification clean");
		end else begin
			$display("natural_log_series_unit_top verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#6000000;
		$display("natural_log_series_unit_top verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/nlsu_pkg.sv
hdl/nlsu_divider.sv
hdl/natural_log_series_unit_top.sv
tb/natural_log_series_unit_top_tb.sv
